// ===== hdl/scalar_literal_classifier_core_macros.svh =====
// assertion macros used by the port-level checker of the literal classifier
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef SCALAR_LITERAL_CLASSIFIER_CORE_MACROS_SVH
`define SCALAR_LITERAL_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define SLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc assertion failed");

// next-cycle implication, ignored while reset is low
`define SLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc assertion failed");

// next-cycle implication checked through reset as well
`define SLC_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("slc reset assertion failed");

`endif

// ===== hdl/slc_pkg.sv =====
// shared types, character codes and lookup functions of the literal classifier
// no dependencies; imported by the front end, queue, back end and top level
package slc_pkg;

  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 3;
  localparam int NUM_SPEC   = 6;
  localparam int SPEC_CHARS = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd5;

  // character codes
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // result kinds
  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_INT     = 3'd1,
    KIND_FLOAT   = 3'd2,
    KIND_DOUBLE  = 3'd3,
    KIND_SPECIAL = 3'd4,
    KIND_BAD     = 3'd5
  } kind_t;

  // position in the float shape
  typedef enum logic [5:0] {
    FP_START = 6'b000001,
    FP_WHOLE = 6'b000010,
    FP_DOT   = 6'b000100,
    FP_FRAC  = 6'b001000,
    FP_F     = 6'b010000,
    FP_DEAD  = 6'b100000
  } fp_phase_t;

  // position in the double shape
  typedef enum logic [3:0] {
    DP_START = 4'b0001,
    DP_WHOLE = 4'b0010,
    DP_FRAC  = 4'b0100,
    DP_DEAD  = 4'b1000
  } dp_phase_t;

  // everything the back end needs to classify a finished token
  typedef struct packed {
    logic [COUNT_W-1:0]  char_count;
    logic [CHAR_W-1:0]   first_char;
    logic                third_is_quote;
    logic                dot_seen;
    logic                f_seen;
    logic                int_ok;
    fp_phase_t           float_phase;
    dp_phase_t           double_phase;
    logic [NUM_SPEC-1:0] special_alive;
  } tok_sum_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [CHAR_W-1:0] c);
    return (c == CH_MINUS) || (c == CH_PLUS);
  endfunction

  // special words, left aligned and padded with zero bytes
  function automatic logic [SPEC_CHARS*CHAR_W-1:0] spec_word(input logic [2:0] k);
    logic [SPEC_CHARS*CHAR_W-1:0] w;
    case (k)
      3'd0:    w = "-inff";
      3'd1:    w = "+inff";
      3'd2:    w = {"-inf", 8'h00};
      3'd3:    w = {"+inf", 8'h00};
      3'd4:    w = {"nanf", 8'h00};
      3'd5:    w = {"nan", 16'h0000};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [COUNT_W-1:0] spec_len(input logic [2:0] k);
    logic [COUNT_W-1:0] n;
    case (k)
      3'd0:    n = 3'd5;
      3'd1:    n = 3'd5;
      3'd2:    n = 3'd4;
      3'd3:    n = 3'd4;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd3;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // byte at position idx (0 to 4) of special word k
  function automatic logic [CHAR_W-1:0] spec_char(input logic [2:0] k,
                                                  input logic [2:0] idx);
    logic [SPEC_CHARS*CHAR_W-1:0] w;
    w = spec_word(k);
    return w[(SPEC_CHARS*CHAR_W-1) - CHAR_W*idx -: CHAR_W];
  endfunction

endpackage

// ===== hdl/slc_front.sv =====
// front end: takes token characters and tracks the per-token flags and phases
// depends on slc_pkg; pushes one token summary into the queue on the last item
module slc_front
  import slc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  input  q_stat_t           q_stat,
  output logic              push,
  output tok_sum_t          push_data
);

  tok_sum_t st_r;
  tok_sum_t st_nxt;
  tok_sum_t st_rst;
  logic     accept;
  logic [2:0] idx_c;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push      = accept && in_last;
  assign push_data = st_nxt;

  // state of a fresh token
  always_comb begin
    st_rst                = '0;
    st_rst.int_ok         = 1'b1;
    st_rst.float_phase    = FP_START;
    st_rst.double_phase   = DP_START;
    st_rst.special_alive  = '1;
  end

  // float shape step
  function automatic fp_phase_t next_float(input fp_phase_t ph,
                                           input logic [CHAR_W-1:0] c);
    fp_phase_t n;
    case (ph)
      FP_START: n = (is_sign(c) || is_digit(c)) ? FP_WHOLE :
                    (c == CH_DOT) ? FP_DOT : FP_DEAD;
      FP_WHOLE: n = is_digit(c) ? FP_WHOLE : (c == CH_DOT) ? FP_DOT : FP_DEAD;
      FP_DOT:   n = is_digit(c) ? FP_FRAC : FP_DEAD;
      FP_FRAC:  n = is_digit(c) ? FP_FRAC : (c == CH_F) ? FP_F : FP_DEAD;
      default:  n = FP_DEAD;
    endcase
    return n;
  endfunction

  // double shape step
  function automatic dp_phase_t next_double(input dp_phase_t ph,
                                            input logic [CHAR_W-1:0] c);
    dp_phase_t n;
    case (ph)
      DP_START: n = (is_sign(c) || is_digit(c)) ? DP_WHOLE :
                    (c == CH_DOT) ? DP_FRAC : DP_DEAD;
      DP_WHOLE: n = is_digit(c) ? DP_WHOLE : (c == CH_DOT) ? DP_FRAC : DP_DEAD;
      DP_FRAC:  n = is_digit(c) ? DP_FRAC : DP_DEAD;
      default:  n = DP_DEAD;
    endcase
    return n;
  endfunction

  // token state after the current character
  always_comb begin
    st_nxt = st_r;
    // position past the end of every word is ruled out by the length check
    idx_c  = (st_r.char_count > 3'd4) ? 3'd4 : st_r.char_count;
    for (int k = 0; k < NUM_SPEC; k++) begin
      st_nxt.special_alive[k] = st_r.special_alive[k] &&
                                (st_r.char_count < spec_len(3'(k))) &&
                                (spec_char(3'(k), idx_c) == in_char);
    end
    if (st_r.char_count == 3'd0) begin
      st_nxt.first_char = in_char;
      st_nxt.int_ok     = st_r.int_ok && (is_digit(in_char) || is_sign(in_char));
    end else begin
      st_nxt.int_ok     = st_r.int_ok && is_digit(in_char);
    end
    if ((st_r.char_count == 3'd2) && (in_char == CH_QUOTE)) begin
      st_nxt.third_is_quote = 1'b1;
    end
    if (in_char == CH_DOT) begin
      st_nxt.dot_seen = 1'b1;
    end
    if (in_char == CH_F) begin
      st_nxt.f_seen = 1'b1;
    end
    st_nxt.float_phase  = next_float(st_r.float_phase, in_char);
    st_nxt.double_phase = next_double(st_r.double_phase, in_char);
    if (st_r.char_count < COUNT_MAX) begin
      st_nxt.char_count = st_r.char_count + 3'd1;
    end
  end

  // token registers, cleared after the last item of a token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (accept) begin
      st_r <= in_last ? st_rst : st_nxt;
    end
  end

endmodule

// ===== hdl/slc_queue.sv =====
// short queue of finished token summaries between front and back end
// depends on slc_pkg; DEPTH of two or more
module slc_queue
  import slc_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tok_sum_t push_data,
  input  logic     pop,
  output tok_sum_t pop_data,
  output q_stat_t  q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_sum_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/slc_back.sv =====
// back end: turns a token summary into its kind and holds it in the output register
// depends on slc_pkg; pops the queue whenever it holds a summary and the output register is free or being taken
module slc_back
  import slc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tok_sum_t q_data,
  input  q_stat_t  q_stat,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output kind_t    out_kind
);

  logic  out_valid_r;
  kind_t out_kind_r;
  kind_t kind_nxt;
  logic  special_hit;

  assign pop       = !q_stat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;

  // classification in priority order: special, then no-dot kinds, then dotted
  always_comb begin
    special_hit = 1'b0;
    for (int k = 0; k < NUM_SPEC; k++) begin
      if (q_data.special_alive[k] && (q_data.char_count == spec_len(3'(k)))) begin
        special_hit = 1'b1;
      end
    end
    if (special_hit) begin
      kind_nxt = KIND_SPECIAL;
    end else if (!q_data.dot_seen) begin
      if ((q_data.char_count == 3'd1) && !is_digit(q_data.first_char)) begin
        kind_nxt = KIND_CHAR;
      end else if ((q_data.char_count == 3'd3) && (q_data.first_char == CH_QUOTE) &&
                   q_data.third_is_quote) begin
        kind_nxt = KIND_CHAR;
      end else if (q_data.int_ok &&
                   !((q_data.char_count == 3'd1) && is_sign(q_data.first_char))) begin
        kind_nxt = KIND_INT;
      end else begin
        kind_nxt = KIND_BAD;
      end
    end else if (q_data.f_seen) begin
      kind_nxt = (q_data.float_phase == FP_F) ? KIND_FLOAT : KIND_BAD;
    end else begin
      kind_nxt = (q_data.double_phase == DP_FRAC) ? KIND_DOUBLE : KIND_BAD;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r <= kind_nxt;
    end
  end

endmodule

// ===== hdl/scalar_literal_classifier_core.sv =====
// top level of the literal classifier: front end, summary queue and back end
// depends on slc_pkg, slc_front, slc_queue and slc_back
//
//  channel | direction | payload
//  in_     | slave     | tdata[7:0] character, tlast marks the token's last item
//  out_    | master    | tdata[2:0] kind, tdata[7:3] zero, one item per token
//
// one character item is taken every cycle while in_tready is high; per-character
// work is a single update of the front end's flag and phase registers
// a token's summary is queued on its last item; its kind is registered when popped
// reset is synchronous and active low and clears all token state at once
// the queue holds QUEUE_DEPTH finished tokens, so in_tready falls only when
// that many results wait behind a stalled out_ side
module scalar_literal_classifier_core
  import slc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] kind, [7:3] zero
);

  logic     push, pop;
  tok_sum_t push_data, pop_data;
  q_stat_t  q_stat;
  kind_t    kind;

  // front end
  slc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // summary queue
  slc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back end
  slc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind)
  );

  assign out_tdata = {5'b0, kind};

endmodule

// ===== hdl/slc_checker.sv =====
// port-level checker for the literal classifier and its bind to the top level
// depends on scalar_literal_classifier_core_macros.svh
`include "scalar_literal_classifier_core_macros.svh"

module slc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result stays offered
  `SLC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its value
  `SLC_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // only defined kinds leave the block
  `SLC_ASSERT_IMP(a_kind_range, clk, rst_n, out_tvalid, out_tdata <= 8'd5)

  // after reset nothing is offered and the input side is open
  `SLC_ASSERT_RST(a_reset_idle, clk, !rst_n, !out_tvalid && in_tready)

endmodule

bind scalar_literal_classifier_core slc_checker u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/slc_kind_checker.sv =====
// checker for the literal classifier: predicts the kind of every token taken on in_
// and compares it with each result item taken on out_; depends on slc_pkg only
module slc_kind_checker
  import slc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  output int         fail_count,
  output int         pending,
  output int         tokens_checked,
  output int         chars_taken,
  output logic [5:0] kinds_seen
);

  // where the token stands in the float and double shapes
  typedef enum logic [2:0] {
    FS_START, FS_WHOLE, FS_POINT, FS_FRAC, FS_SUFFIX, FS_DEAD
  } float_shape_t;

  typedef enum logic [1:0] {
    DS_START, DS_WHOLE, DS_FRAC, DS_DEAD
  } double_shape_t;

  // token in progress
  int            tok_len;
  logic [39:0]   head;
  logic [7:0]    first_byte;
  logic          third_quote;
  logic          has_dot;
  logic          has_f;
  logic          int_shape;
  float_shape_t  fshape;
  double_shape_t dshape;

  kind_t expected_kinds [$];

  function automatic logic numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic sign_char(input logic [7:0] c);
    return c == CH_MINUS || c == CH_PLUS;
  endfunction

  function automatic float_shape_t float_next(input float_shape_t s, input logic [7:0] c);
    case (s)
      FS_START: return (numeral(c) || sign_char(c)) ? FS_WHOLE :
                       (c == CH_DOT) ? FS_POINT : FS_DEAD;
      FS_WHOLE: return numeral(c) ? FS_WHOLE : (c == CH_DOT) ? FS_POINT : FS_DEAD;
      FS_POINT: return numeral(c) ? FS_FRAC : FS_DEAD;
      FS_FRAC:  return numeral(c) ? FS_FRAC : (c == CH_F) ? FS_SUFFIX : FS_DEAD;
      default:  return FS_DEAD;
    endcase
  endfunction

  function automatic double_shape_t double_next(input double_shape_t s,
                                                input logic [7:0] c);
    case (s)
      DS_START: return (numeral(c) || sign_char(c)) ? DS_WHOLE :
                       (c == CH_DOT) ? DS_FRAC : DS_DEAD;
      DS_WHOLE: return numeral(c) ? DS_WHOLE : (c == CH_DOT) ? DS_FRAC : DS_DEAD;
      DS_FRAC:  return numeral(c) ? DS_FRAC : DS_DEAD;
      default:  return DS_DEAD;
    endcase
  endfunction

  // the whole token spells one of the special words
  function automatic logic special_word();
    case (tok_len)
      3:       return head[23:0] == "nan";
      4:       return head[31:0] == "-inf" || head[31:0] == "+inf" ||
                      head[31:0] == "nanf";
      5:       return head == "-inff" || head == "+inff";
      default: return 1'b0;
    endcase
  endfunction

  function automatic kind_t token_kind();
    if (special_word())
      return KIND_SPECIAL;
    if (!has_dot) begin
      if (tok_len == 1 && !numeral(first_byte))
        return KIND_CHAR;
      if (tok_len == 3 && first_byte == CH_QUOTE && third_quote)
        return KIND_CHAR;
      if (int_shape && !(tok_len == 1 && sign_char(first_byte)))
        return KIND_INT;
      return KIND_BAD;
    end
    if (has_f)
      return (fshape == FS_SUFFIX) ? KIND_FLOAT : KIND_BAD;
    return (dshape == DS_FRAC) ? KIND_DOUBLE : KIND_BAD;
  endfunction

  task automatic clear_token();
    tok_len     = 0;
    head        = '0;
    first_byte  = '0;
    third_quote = 1'b0;
    has_dot     = 1'b0;
    has_f       = 1'b0;
    int_shape   = 1'b1;
    fshape      = FS_START;
    dshape      = DS_START;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    if (tok_len == 0) begin
      first_byte = c;
      int_shape  = numeral(c) || sign_char(c);
    end else if (!numeral(c)) begin
      int_shape = 1'b0;
    end
    if (tok_len == 2 && c == CH_QUOTE)
      third_quote = 1'b1;
    if (c == CH_DOT)
      has_dot = 1'b1;
    if (c == CH_F)
      has_f = 1'b1;
    fshape = float_next(fshape, c);
    dshape = double_next(dshape, c);
    // only the first five bytes can matter for a special word
    if (tok_len < 5)
      head = {head[31:0], c};
    if (tok_len < 6)
      tok_len++;
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    kind_t want;
    if (!rst_n) begin
      clear_token();
      expected_kinds.delete();
      fail_count     = 0;
      tokens_checked = 0;
      chars_taken    = 0;
      kinds_seen     = '0;
    end else begin
      // result side first: a result never shares an edge with its own last item
      if (out_tvalid && out_tready) begin
        if (expected_kinds.size() == 0) begin
          $error("kind result with no token pending: got %0d", out_tdata[2:0]);
          fail_count++;
        end else begin
          want = expected_kinds.pop_front();
          tokens_checked++;
          if (out_tdata[2:0] !== want) begin
            $error("kind mismatch: expected %0d (%s), got %0d",
                   want, want.name(), out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[7:3] !== 5'd0) begin
            $error("tdata[7:3] mismatch: expected 0, got %0d", out_tdata[7:3]);
            fail_count++;
          end
        end
      end
      // character side
      if (in_tvalid && in_tready) begin
        chars_taken++;
        absorb_char(in_tdata);
        if (in_tlast) begin
          want = token_kind();
          expected_kinds.push_back(want);
          kinds_seen[want] = 1'b1;
          clear_token();
        end
      end
    end
    pending = expected_kinds.size();
  end

endmodule

// ===== bench/scalar_literal_classifier_core_tb.sv =====
// testbench top of the literal classifier: clock, reset, token stimulus and verdict
// depends on slc_pkg, scalar_literal_classifier_core and slc_kind_checker
module scalar_literal_classifier_core_tb
  import slc_pkg::*;
;

  localparam int CHAR_TARGET = 1250;
  localparam int HOLD_CYCLES = 300;

  typedef logic [7:0] text_t [$];

  // shapes of well-formed tokens and the edits applied to break them
  typedef enum int {SH_INT, SH_FLOAT, SH_DOUBLE, SH_CHAR, SH_QUOTED, SH_SPECIAL} shape_t;
  typedef enum int {ED_SWAP, ED_DROP, ED_ADD} edit_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] character
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [2:0] kind, [7:3] zero

  int         fail_count;
  int         pending;
  int         tokens_checked;
  int         chars_taken;
  logic [5:0] kinds_seen;

  int chars_sent = 0;
  int burst_left = 0;
  int drains     = 0;
  int held       = 0;

  scalar_literal_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  slc_kind_checker kind_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked),
    .chars_taken    (chars_taken),
    .kinds_seen     (kinds_seen)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #(8 * 250000);
    $display("status: fail");
    $finish;
  end

  function automatic text_t word(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++)
      t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] sign_byte();
    return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
  endfunction

  // bytes weighted towards the ones the classifier cares about
  function automatic logic [7:0] lively_byte();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: b = digit_byte();
      4:          b = CH_DOT;
      5:          b = CH_F;
      6:          b = CH_MINUS;
      7:          b = CH_PLUS;
      8:          b = CH_QUOTE;
      9:          b = $urandom_range(0, 1) ? "n" : ($urandom_range(0, 1) ? "a" : "i");
      default:    b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  function automatic text_t well_formed(input shape_t s);
    text_t t;
    case (s)
      SH_INT: begin
        if ($urandom_range(0, 2) == 0)
          t.push_back(sign_byte());
        repeat ($urandom_range(1, 4)) t.push_back(digit_byte());
      end
      SH_FLOAT, SH_DOUBLE: begin
        if ($urandom_range(0, 2) == 0)
          t.push_back(sign_byte());
        repeat ($urandom_range(0, 3)) t.push_back(digit_byte());
        t.push_back(CH_DOT);
        repeat ($urandom_range(s == SH_FLOAT ? 1 : 0, 3)) t.push_back(digit_byte());
        if (s == SH_FLOAT)
          t.push_back(CH_F);
      end
      SH_CHAR:
        t.push_back(8'($urandom_range(0, 255)));
      SH_QUOTED: begin
        t.push_back(CH_QUOTE);
        t.push_back(8'($urandom_range(0, 255)));
        t.push_back(CH_QUOTE);
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       t = word("-inff");
          1:       t = word("+inff");
          2:       t = word("-inf");
          3:       t = word("+inf");
          4:       t = word("nanf");
          default: t = word("nan");
        endcase
      end
    endcase
    return t;
  endfunction

  // one edit at a random position of a well-formed token
  function automatic text_t mutate(input text_t t);
    int p;
    p = $urandom_range(0, t.size() - 1);
    case (edit_t'($urandom_range(0, 2)))
      ED_SWAP: t[p] = lively_byte();
      ED_DROP: if (t.size() > 1) t.delete(p); else t[p] = lively_byte();
      default: t.insert(p, lively_byte());
    endcase
    return t;
  endfunction

  function automatic text_t random_token();
    text_t t;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      t = well_formed(shape_t'($urandom_range(0, 5)));
    end else if (r < 78) begin
      t = mutate(well_formed(shape_t'($urandom_range(0, 5))));
    end else if (r < 93) begin
      repeat ($urandom_range(1, 6))
        t.push_back($urandom_range(0, 1) ? lively_byte() : 8'($urandom_range(0, 255)));
    end else begin
      // long tokens push the count past every special word
      repeat ($urandom_range(6, 12)) t.push_back(lively_byte());
    end
    return t;
  endfunction

  // offer one character, idling between bursts
  task automatic put_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_token(input text_t t);
    for (int i = 0; i < t.size(); i++)
      put_char(t[i], i == t.size() - 1);
  endtask

  // stop offering until every expected kind has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    drains++;
  endtask

  // result side: changing stall patterns and one long hold-off
  initial begin
    int taken;
    int mode;
    int mode_left;
    int hold_left;
    logic rdy;
    taken     = 0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_tvalid && out_tready)
        taken++;
      if (held == 0 && taken >= 60) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
      @(posedge clk);
    end
  end

  // reset, stimulus and verdict
  initial begin
    logic mid_drain;
    mid_drain = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed tokens: specials, sign alone, lone dot, byte extremes, each kind
    send_token(word("-inff"));
    send_token(word("nan"));
    send_token(word("+"));
    send_token(word("."));
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b1);
    send_token(word("'a'"));
    send_token(word("7"));
    send_token(word("-3"));
    send_token(word(".5f"));
    send_token(word("1."));
    send_token(word("nanff0"));
    drain();

    // random tokens, mostly well-formed
    while (chars_sent < CHAR_TARGET) begin
      if (!mid_drain && chars_sent >= CHAR_TARGET / 2) begin
        mid_drain = 1'b1;
        drain();
      end
      send_token(random_token());
    end

    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d tokens over %0d characters, kinds seen %b (bit per kind code)",
             tokens_checked, chars_taken, kinds_seen);
    $display("result side held off %0d cycles once, input drained %0d times",
             HOLD_CYCLES, drains);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
